### hw/rtl/sip_pkg.sv
// Shared types and constants for the segment intersection pipeline.
// No dependencies; every other file of the block imports it.
`default_nettype none

package sip_pkg;

    // Lanes of the scaling and divide path: one per output coordinate.
    localparam int LANES   = 4;
    localparam int LANE_XA = 0;
    localparam int LANE_YA = 1;
    localparam int LANE_XB = 2;
    localparam int LANE_YB = 3;

    // Control that travels alongside the data of one transfer.
    typedef struct packed {
        logic             valid;
        logic             hit;
        logic [LANES-1:0] neg;    // sign of the lane's segment delta
    } t_ctrl;

endpackage

`default_nettype wire

### hw/rtl/sip_front.sv
// Front end: deltas, cross products, numerators, denominator and hit test.
// Four register stages. Depends on sip_pkg.
`default_nettype none

module sip_front #(
    parameter int W = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    input  logic signed [W-1:0]                    i_ax1,
    input  logic signed [W-1:0]                    i_ay1,
    input  logic signed [W-1:0]                    i_ax2,
    input  logic signed [W-1:0]                    i_ay2,
    input  logic signed [W-1:0]                    i_bx1,
    input  logic signed [W-1:0]                    i_by1,
    input  logic signed [W-1:0]                    i_bx2,
    input  logic signed [W-1:0]                    i_by2,
    output sip_pkg::t_ctrl                         o_ctrl,
    output logic [sip_pkg::LANES-1:0][W-1:0]       o_start,
    output logic [sip_pkg::LANES-1:0][W-1:0]       o_dmag,
    output logic [sip_pkg::LANES-1:0][2*W:0]       o_nmag,
    output logic [2*W:0]                           o_den
);
    import sip_pkg::*;

    localparam int DW = W + 1;      // signed delta
    localparam int NW = 2 * W + 2;  // signed product, numerator, denominator
    localparam int MW = 2 * W + 1;  // magnitude of a numerator or denominator

    function automatic logic in_unit(input logic signed [NW-1:0] num,
                                     input logic signed [NW-1:0] den);
        logic pos;
        logic neg;
        pos = (num >= 0) && (num <= den);
        neg = (num <= 0) && (num >= den);
        return den[NW-1] ? neg : pos;
    endfunction

    function automatic logic [MW-1:0] mag_n(input logic signed [NW-1:0] v);
        logic signed [NW-1:0] a;
        a = v[NW-1] ? -v : v;
        return a[MW-1:0];
    endfunction

    function automatic logic [W-1:0] mag_d(input logic signed [DW-1:0] v);
        logic signed [DW-1:0] a;
        a = v[DW-1] ? -v : v;
        return a[W-1:0];
    endfunction

    // stage 1: differences
    logic                               r_s1_valid;
    logic signed [DW-1:0]               r_s1_dxa, r_s1_dya, r_s1_dxb, r_s1_dyb;
    logic signed [DW-1:0]               r_s1_ox, r_s1_oy;
    logic [LANES-1:0][W-1:0]            r_s1_start;
    // stage 2: cross products
    logic                               r_s2_valid;
    logic signed [NW-1:0]               r_s2_pden1, r_s2_pden2;
    logic signed [NW-1:0]               r_s2_pa1, r_s2_pa2, r_s2_pb1, r_s2_pb2;
    logic [LANES-1:0][DW-1:0]           r_s2_d;
    logic [LANES-1:0][W-1:0]            r_s2_start;
    // stage 3: numerators and denominator
    logic                               r_s3_valid;
    logic signed [NW-1:0]               r_s3_den, r_s3_na, r_s3_nb;
    logic [LANES-1:0][DW-1:0]           r_s3_d;
    logic [LANES-1:0][W-1:0]            r_s3_start;
    // stage 4: hit test and magnitudes
    t_ctrl                              r_s4_ctrl;
    t_ctrl                              n_s4_ctrl;
    logic [LANES-1:0][W-1:0]            r_s4_start;
    logic [LANES-1:0][W-1:0]            r_s4_dmag;
    logic [LANES-1:0][MW-1:0]           r_s4_nmag;
    logic [MW-1:0]                      r_s4_den;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
            r_s4_ctrl  <= '0;
        end else begin
            r_s1_valid <= i_valid;
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid;
            r_s4_ctrl  <= n_s4_ctrl;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_dxa <= DW'(i_ax2) - DW'(i_ax1);
        r_s1_dya <= DW'(i_ay2) - DW'(i_ay1);
        r_s1_dxb <= DW'(i_bx2) - DW'(i_bx1);
        r_s1_dyb <= DW'(i_by2) - DW'(i_by1);
        r_s1_ox  <= DW'(i_ax1) - DW'(i_bx1);
        r_s1_oy  <= DW'(i_ay1) - DW'(i_by1);
        r_s1_start[LANE_XA] <= i_ax1;
        r_s1_start[LANE_YA] <= i_ay1;
        r_s1_start[LANE_XB] <= i_bx1;
        r_s1_start[LANE_YB] <= i_by1;

        r_s2_pden1 <= NW'(r_s1_dyb) * NW'(r_s1_dxa);
        r_s2_pden2 <= NW'(r_s1_dxb) * NW'(r_s1_dya);
        r_s2_pa1   <= NW'(r_s1_dxb) * NW'(r_s1_oy);
        r_s2_pa2   <= NW'(r_s1_dyb) * NW'(r_s1_ox);
        r_s2_pb1   <= NW'(r_s1_dxa) * NW'(r_s1_oy);
        r_s2_pb2   <= NW'(r_s1_dya) * NW'(r_s1_ox);
        r_s2_d[LANE_XA] <= r_s1_dxa;
        r_s2_d[LANE_YA] <= r_s1_dya;
        r_s2_d[LANE_XB] <= r_s1_dxb;
        r_s2_d[LANE_YB] <= r_s1_dyb;
        r_s2_start <= r_s1_start;

        r_s3_den   <= r_s2_pden1 - r_s2_pden2;
        r_s3_na    <= r_s2_pa1 - r_s2_pa2;
        r_s3_nb    <= r_s2_pb1 - r_s2_pb2;
        r_s3_d     <= r_s2_d;
        r_s3_start <= r_s2_start;

        r_s4_start <= r_s3_start;
        r_s4_den   <= mag_n(r_s3_den);
        r_s4_nmag[LANE_XA] <= mag_n(r_s3_na);
        r_s4_nmag[LANE_YA] <= mag_n(r_s3_na);
        r_s4_nmag[LANE_XB] <= mag_n(r_s3_nb);
        r_s4_nmag[LANE_YB] <= mag_n(r_s3_nb);
        for (int l = 0; l < LANES; l++) begin
            r_s4_dmag[l] <= mag_d($signed(r_s3_d[l]));
        end
    end

    always_comb begin
        n_s4_ctrl.valid = r_s3_valid;
        n_s4_ctrl.hit   = (r_s3_den != 0) && in_unit(r_s3_na, r_s3_den)
                          && in_unit(r_s3_nb, r_s3_den);
        for (int l = 0; l < LANES; l++) begin
            n_s4_ctrl.neg[l] = r_s3_d[l][DW-1];
        end
    end

    assign o_ctrl  = r_s4_ctrl;
    assign o_start = r_s4_start;
    assign o_dmag  = r_s4_dmag;
    assign o_nmag  = r_s4_nmag;
    assign o_den   = r_s4_den;

endmodule

`default_nettype wire

### hw/rtl/sip_scale.sv
// Scaling: numerator magnitude times delta magnitude, split in two halves
// over two register stages. Depends on sip_pkg.
`default_nettype none

module sip_scale #(
    parameter int W = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  sip_pkg::t_ctrl                         i_ctrl,
    input  logic [sip_pkg::LANES-1:0][W-1:0]       i_start,
    input  logic [sip_pkg::LANES-1:0][W-1:0]       i_dmag,
    input  logic [sip_pkg::LANES-1:0][2*W:0]       i_nmag,
    input  logic [2*W:0]                           i_den,
    output sip_pkg::t_ctrl                         o_ctrl,
    output logic [sip_pkg::LANES-1:0][W-1:0]       o_start,
    output logic [sip_pkg::LANES-1:0][3*W:0]       o_prod,
    output logic [2*W:0]                           o_den
);
    import sip_pkg::*;

    localparam int MW = 2 * W + 1;
    localparam int RW = 3 * W + 1;
    localparam int H  = W / 2;
    localparam int HH = W - H;

    t_ctrl                          r_s5_ctrl;
    logic [LANES-1:0][W-1:0]        r_s5_start;
    logic [LANES-1:0][MW+H-1:0]     r_s5_lo;
    logic [LANES-1:0][MW+HH-1:0]    r_s5_hi;
    logic [MW-1:0]                  r_s5_den;
    t_ctrl                          r_s6_ctrl;
    logic [LANES-1:0][W-1:0]        r_s6_start;
    logic [LANES-1:0][RW-1:0]       r_s6_prod;
    logic [MW-1:0]                  r_s6_den;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s5_ctrl <= '0;
            r_s6_ctrl <= '0;
        end else begin
            r_s5_ctrl <= i_ctrl;
            r_s6_ctrl <= r_s5_ctrl;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int l = 0; l < LANES; l++) begin
            r_s5_lo[l] <= (MW+H)'(i_nmag[l]) * (MW+H)'(i_dmag[l][H-1:0]);
            r_s5_hi[l] <= (MW+HH)'(i_nmag[l]) * (MW+HH)'(i_dmag[l][W-1:H]);
            r_s6_prod[l] <= (RW'(r_s5_hi[l]) << H) + RW'(r_s5_lo[l]);
        end
        r_s5_start <= i_start;
        r_s5_den   <= i_den;
        r_s6_start <= r_s5_start;
        r_s6_den   <= r_s5_den;
    end

    assign o_ctrl  = r_s6_ctrl;
    assign o_start = r_s6_start;
    assign o_prod  = r_s6_prod;
    assign o_den   = r_s6_den;

endmodule

`default_nettype wire

### hw/rtl/sip_div_cell.sv
// One cell of the divide chain: settles quotient bit SHIFT for every lane
// against the shared denominator and hands on to the next cell. Depends on sip_pkg.
`default_nettype none

module sip_div_cell #(
    parameter int W     = 16,
    parameter int SHIFT = 0
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  sip_pkg::t_ctrl                         i_ctrl,
    input  logic [sip_pkg::LANES-1:0][W-1:0]       i_start,
    input  logic [sip_pkg::LANES-1:0][3*W:0]       i_rem,
    input  logic [sip_pkg::LANES-1:0][W-1:0]       i_quo,
    input  logic [2*W:0]                           i_den,
    output sip_pkg::t_ctrl                         o_ctrl,
    output logic [sip_pkg::LANES-1:0][W-1:0]       o_start,
    output logic [sip_pkg::LANES-1:0][3*W:0]       o_rem,
    output logic [sip_pkg::LANES-1:0][W-1:0]       o_quo,
    output logic [2*W:0]                           o_den
);
    import sip_pkg::*;

    localparam int RW = 3 * W + 1;

    logic [RW-1:0]              den_sh;
    logic [LANES-1:0][RW-1:0]   n_rem;
    logic [LANES-1:0][W-1:0]    n_quo;
    t_ctrl                      r_ctrl;
    logic [LANES-1:0][W-1:0]    r_start;
    logic [LANES-1:0][RW-1:0]   r_rem;
    logic [LANES-1:0][W-1:0]    r_quo;
    logic [2*W:0]               r_den;

    assign den_sh = RW'(i_den) << SHIFT;

    // restoring step: take the shifted denominator off where it fits
    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            if (i_rem[l] >= den_sh) begin
                n_rem[l] = i_rem[l] - den_sh;
                n_quo[l] = i_quo[l] | (W'(1) << SHIFT);
            end else begin
                n_rem[l] = i_rem[l];
                n_quo[l] = i_quo[l];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl <= '0;
        end else begin
            r_ctrl <= i_ctrl;
        end
    end

    always_ff @(posedge i_clk) begin
        r_start <= i_start;
        r_rem   <= n_rem;
        r_quo   <= n_quo;
        r_den   <= i_den;
    end

    assign o_ctrl  = r_ctrl;
    assign o_start = r_start;
    assign o_rem   = r_rem;
    assign o_quo   = r_quo;
    assign o_den   = r_den;

endmodule

`default_nettype wire

### hw/rtl/segment_intersection_point.sv
// Top level of the segment intersection pipeline.
// Uses sip_pkg, sip_front, sip_scale and sip_div_cell.
//
// Usage:
//   Drive both segments on the i_seg_* ports and raise start; a transfer is
//   taken at each rising edge with start high and busy low. busy is low at
//   all times outside reset, so one pair of segments may enter every cycle.
//   Each result appears for exactly one cycle with o_valid high, carrying
//   o_hit and the crossing point computed along each segment; the four
//   coordinates read zero when there is no hit. The receiver cannot stall,
//   so results are never held back and no storage is needed between them.
//
// Pipeline and throughput:
//   Results leave in the order of their transfers, after passing through
//   four front stages (deltas, cross products, numerators, hit test), two
//   stages for the split numerator-times-delta product, one divide cell per
//   quotient bit (COORD_WIDTH cells, one restoring step each) and one output
//   stage. One transfer per cycle is sustained; the chain of divide cells
//   sets the latency.
//
// Reset:
//   Synchronous, active low. Drops every item in flight; busy is high while
//   reset is held.
`default_nettype none

module segment_intersection_point #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic signed [COORD_WIDTH-1:0]  i_seg_a_x1,
    input  logic signed [COORD_WIDTH-1:0]  i_seg_a_y1,
    input  logic signed [COORD_WIDTH-1:0]  i_seg_a_x2,
    input  logic signed [COORD_WIDTH-1:0]  i_seg_a_y2,
    input  logic signed [COORD_WIDTH-1:0]  i_seg_b_x1,
    input  logic signed [COORD_WIDTH-1:0]  i_seg_b_y1,
    input  logic signed [COORD_WIDTH-1:0]  i_seg_b_x2,
    input  logic signed [COORD_WIDTH-1:0]  i_seg_b_y2,
    output logic                           o_valid,
    output logic                           o_hit,
    output logic signed [COORD_WIDTH-1:0]  o_cross_x_a,
    output logic signed [COORD_WIDTH-1:0]  o_cross_y_a,
    output logic signed [COORD_WIDTH-1:0]  o_cross_x_b,
    output logic signed [COORD_WIDTH-1:0]  o_cross_y_b
);
    import sip_pkg::*;

    localparam int W       = COORD_WIDTH;
    localparam int MW      = 2 * W + 1;   // magnitude of numerator or denominator
    localparam int RW      = 3 * W + 1;   // scaled dividend
    localparam int LATENCY = W + 7;

    logic accept;

    // front end to scaling
    t_ctrl                      front_ctrl;
    logic [LANES-1:0][W-1:0]    front_start;
    logic [LANES-1:0][W-1:0]    front_dmag;
    logic [LANES-1:0][MW-1:0]   front_nmag;
    logic [MW-1:0]              front_den;

    // divide chain taps, one set per cell boundary
    t_ctrl                      ctrl_c  [0:W];
    logic [LANES-1:0][W-1:0]    start_c [0:W];
    logic [LANES-1:0][RW-1:0]   rem_c   [0:W];
    logic [LANES-1:0][W-1:0]    quo_c   [0:W];
    logic [MW-1:0]              den_c   [0:W];

    // output stage
    logic                       r_valid;
    logic                       r_hit;
    logic [LANES-1:0][W-1:0]    r_cross;
    logic [LANES-1:0][W-1:0]    n_cross;

    // no transfer is taken while reset is held
    assign busy   = ~i_rst_n;
    assign accept = start & ~busy;

    sip_front #(
        .W (W)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (accept),
        .i_ax1   (i_seg_a_x1),
        .i_ay1   (i_seg_a_y1),
        .i_ax2   (i_seg_a_x2),
        .i_ay2   (i_seg_a_y2),
        .i_bx1   (i_seg_b_x1),
        .i_by1   (i_seg_b_y1),
        .i_bx2   (i_seg_b_x2),
        .i_by2   (i_seg_b_y2),
        .o_ctrl  (front_ctrl),
        .o_start (front_start),
        .o_dmag  (front_dmag),
        .o_nmag  (front_nmag),
        .o_den   (front_den)
    );

    sip_scale #(
        .W (W)
    ) u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (front_ctrl),
        .i_start (front_start),
        .i_dmag  (front_dmag),
        .i_nmag  (front_nmag),
        .i_den   (front_den),
        .o_ctrl  (ctrl_c[0]),
        .o_start (start_c[0]),
        .o_prod  (rem_c[0]),
        .o_den   (den_c[0])
    );

    // quotient starts empty; each cell fills one bit, most significant first
    assign quo_c[0] = '0;

    for (genvar i = 0; i < W; i++) begin : g_div
        sip_div_cell #(
            .W     (W),
            .SHIFT (W - 1 - i)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctrl  (ctrl_c[i]),
            .i_start (start_c[i]),
            .i_rem   (rem_c[i]),
            .i_quo   (quo_c[i]),
            .i_den   (den_c[i]),
            .o_ctrl  (ctrl_c[i+1]),
            .o_start (start_c[i+1]),
            .o_rem   (rem_c[i+1]),
            .o_quo   (quo_c[i+1]),
            .o_den   (den_c[i+1])
        );
    end

    // Apply the delta's sign to the truncated quotient and add the start
    // point. On a hit the point lies on the segment, so it fits its field.
    always_comb begin
        logic [W:0] sq;
        logic [W:0] sum;
        for (int l = 0; l < LANES; l++) begin
            sq  = {1'b0, quo_c[W][l]};
            if (ctrl_c[W].neg[l]) begin
                sq = -sq;
            end
            sum = {start_c[W][l][W-1], start_c[W][l]} + sq;
            n_cross[l] = ctrl_c[W].hit ? sum[W-1:0] : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= ctrl_c[W].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hit   <= ctrl_c[W].hit;
        r_cross <= n_cross;
    end

    assign o_valid     = r_valid;
    assign o_hit       = r_hit;
    assign o_cross_x_a = $signed(r_cross[LANE_XA]);
    assign o_cross_y_a = $signed(r_cross[LANE_YA]);
    assign o_cross_x_b = $signed(r_cross[LANE_XB]);
    assign o_cross_y_b = $signed(r_cross[LANE_YB]);

`ifndef NO_ASSERTIONS
    // every accepted transfer must produce a result strobe once it has passed the whole pipeline
    a_latency : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##LATENCY r_valid)
        else $error("result missing at the fixed latency");

    // a hit must never come from a zero denominator
    a_hit_den : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (front_ctrl.valid && front_ctrl.hit) |-> (front_den != '0))
        else $error("hit flagged with zero denominator");

    // on a hit the divide chain must leave a remainder below the denominator
    a_rem : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ctrl_c[W].valid && ctrl_c[W].hit) |->
            ((rem_c[W][LANE_XA] < RW'(den_c[W])) && (rem_c[W][LANE_YA] < RW'(den_c[W]))
             && (rem_c[W][LANE_XB] < RW'(den_c[W]))
             && (rem_c[W][LANE_YB] < RW'(den_c[W]))))
        else $error("divide remainder not below denominator");
`endif

endmodule

`default_nettype wire

### tb/sv/sip_crossing_checker.sv
// Checker for the segment intersection pipeline: predicts each crossing and compares.
// Watches the transfer and result ports of segment_intersection_point; no other dependencies.

module sip_crossing_checker #(
    parameter int CW = 16
) (
    input  logic                  i_clk,
    input  logic                  start,
    input  logic                  busy,
    input  logic signed [CW-1:0]  i_seg_a_x1,
    input  logic signed [CW-1:0]  i_seg_a_y1,
    input  logic signed [CW-1:0]  i_seg_a_x2,
    input  logic signed [CW-1:0]  i_seg_a_y2,
    input  logic signed [CW-1:0]  i_seg_b_x1,
    input  logic signed [CW-1:0]  i_seg_b_y1,
    input  logic signed [CW-1:0]  i_seg_b_x2,
    input  logic signed [CW-1:0]  i_seg_b_y2,
    input  logic                  o_valid,
    input  logic                  o_hit,
    input  logic signed [CW-1:0]  o_cross_x_a,
    input  logic signed [CW-1:0]  o_cross_y_a,
    input  logic signed [CW-1:0]  o_cross_x_b,
    input  logic signed [CW-1:0]  o_cross_y_b,
    output int                    mismatches,
    output int                    awaiting,
    output int                    results_seen,
    output int                    hits_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic signed [CW-1:0] coord_t;

    typedef struct packed {
        logic   hit;
        coord_t x_a;
        coord_t y_a;
        coord_t x_b;
        coord_t y_b;
    } crossing_t;

    crossing_t expected_crossings [$];

    int fail_tally   = 0;
    int queued       = 0;
    int result_tally = 0;
    int hit_tally    = 0;

    assign mismatches   = fail_tally;
    assign awaiting     = queued;
    assign results_seen = result_tally;
    assign hits_seen    = hit_tally;

    // num/den in [0,1], decided by sign and magnitude; den is nonzero
    function automatic bit within_unit(input longint num, input longint den);
        if (den > 0)
            return num >= 0 && num <= den;
        return num <= 0 && num >= den;
    endfunction

    function automatic crossing_t crossing_of(
        input longint x1, input longint y1, input longint x2, input longint y2,
        input longint x3, input longint y3, input longint x4, input longint y4
    );
        longint    dxa, dya, dxb, dyb, ox, oy, den, num_a, num_b;
        crossing_t r;
        dxa   = x2 - x1;
        dya   = y2 - y1;
        dxb   = x4 - x3;
        dyb   = y4 - y3;
        ox    = x1 - x3;
        oy    = y1 - y3;
        den   = dyb * dxa - dxb * dya;
        num_a = dxb * oy - dyb * ox;
        num_b = dxa * oy - dya * ox;
        r     = '0;
        if (den != 0 && within_unit(num_a, den) && within_unit(num_b, den)) begin
            // quotients truncate toward zero, as the divide cells do
            r.hit = 1'b1;
            r.x_a = coord_t'(x1 + (num_a * dxa) / den);
            r.y_a = coord_t'(y1 + (num_a * dya) / den);
            r.x_b = coord_t'(x3 + (num_b * dxb) / den);
            r.y_b = coord_t'(y3 + (num_b * dyb) / den);
        end
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("ERROR at %0t ns: %s", $time, msg);
        fail_tally++;
    endtask

    task automatic check_field(input string name, input logic signed [63:0] got,
                               input logic signed [63:0] want);
        if (got !== want)
            report_mismatch($sformatf("result %0d: %s is %0d, expected %0d",
                                      result_tally, name, got, want));
    endtask

    // Compare the strobed result first, then log the transfer of this edge.
    always @(posedge i_clk) begin
        crossing_t want;
        if (o_valid) begin
            if (expected_crossings.size() == 0) begin
                report_mismatch($sformatf("result %0d strobed with no transfer awaiting it",
                                          result_tally));
            end else begin
                want = expected_crossings.pop_front();
                check_field("hit", o_hit, want.hit);
                check_field("cross_x_a", o_cross_x_a, want.x_a);
                check_field("cross_y_a", o_cross_y_a, want.y_a);
                check_field("cross_x_b", o_cross_x_b, want.x_b);
                check_field("cross_y_b", o_cross_y_b, want.y_b);
                hit_tally += want.hit;
            end
            result_tally++;
        end
        if (start && !busy)
            expected_crossings = {expected_crossings,
                                  crossing_of(i_seg_a_x1, i_seg_a_y1,
                                              i_seg_a_x2, i_seg_a_y2,
                                              i_seg_b_x1, i_seg_b_y1,
                                              i_seg_b_x2, i_seg_b_y2)};
        queued = expected_crossings.size();
    end

endmodule

### tb/sv/tb.sv
// Testbench top for segment_intersection_point: clock, reset, stimulus and verdict.
// Depends on the block's RTL and on sip_crossing_checker, which does all the checking.

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CW         = 16;
    localparam int LATENCY    = CW + 7;      // transfer to result strobe
    localparam int N_RANDOM   = 650;
    localparam int CALM_TAIL  = 100;         // last random transfers go back to back
    localparam int DRAIN_WAIT = 8 * LATENCY; // cap on any wait for results

    typedef logic signed [CW-1:0] coord_t;

    logic   i_clk;
    logic   i_rst_n;
    logic   start;
    logic   busy;
    coord_t i_seg_a_x1, i_seg_a_y1, i_seg_a_x2, i_seg_a_y2;
    coord_t i_seg_b_x1, i_seg_b_y1, i_seg_b_x2, i_seg_b_y2;
    logic   o_valid;
    logic   o_hit;
    coord_t o_cross_x_a, o_cross_y_a, o_cross_x_b, o_cross_y_b;

    int mismatches;
    int awaiting;
    int results_seen;
    int hits_seen;

    int transfers = 0;
    int pair_coords [8];   // a_x1, a_y1, a_x2, a_y2, b_x1, b_y1, b_x2, b_y2

    segment_intersection_point #(
        .COORD_WIDTH (CW)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_seg_a_x1  (i_seg_a_x1),
        .i_seg_a_y1  (i_seg_a_y1),
        .i_seg_a_x2  (i_seg_a_x2),
        .i_seg_a_y2  (i_seg_a_y2),
        .i_seg_b_x1  (i_seg_b_x1),
        .i_seg_b_y1  (i_seg_b_y1),
        .i_seg_b_x2  (i_seg_b_x2),
        .i_seg_b_y2  (i_seg_b_y2),
        .o_valid     (o_valid),
        .o_hit       (o_hit),
        .o_cross_x_a (o_cross_x_a),
        .o_cross_y_a (o_cross_y_a),
        .o_cross_x_b (o_cross_x_b),
        .o_cross_y_b (o_cross_y_b)
    );

    sip_crossing_checker #(
        .CW (CW)
    ) crossing_checker (
        .i_clk        (i_clk),
        .start        (start),
        .busy         (busy),
        .i_seg_a_x1   (i_seg_a_x1),
        .i_seg_a_y1   (i_seg_a_y1),
        .i_seg_a_x2   (i_seg_a_x2),
        .i_seg_a_y2   (i_seg_a_y2),
        .i_seg_b_x1   (i_seg_b_x1),
        .i_seg_b_y1   (i_seg_b_y1),
        .i_seg_b_x2   (i_seg_b_x2),
        .i_seg_b_y2   (i_seg_b_y2),
        .o_valid      (o_valid),
        .o_hit        (o_hit),
        .o_cross_x_a  (o_cross_x_a),
        .o_cross_y_a  (o_cross_y_a),
        .o_cross_x_b  (o_cross_x_b),
        .o_cross_y_b  (o_cross_y_b),
        .mismatches   (mismatches),
        .awaiting     (awaiting),
        .results_seen (results_seen),
        .hits_seen    (hits_seen)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Backstop: a correct run needs well under a tenth of this.
    initial begin
        #500us;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Present one pair and hold it until the edge that takes the transfer.
    // The caller returns on that edge, so the next drive lands in the same step
    // and start stays high without a drop between back-to-back transfers.
    task automatic issue_pair(input int ax1, input int ay1, input int ax2, input int ay2,
                              input int bx1, input int by1, input int bx2, input int by2);
        i_seg_a_x1 <= coord_t'(ax1);
        i_seg_a_y1 <= coord_t'(ay1);
        i_seg_a_x2 <= coord_t'(ax2);
        i_seg_a_y2 <= coord_t'(ay2);
        i_seg_b_x1 <= coord_t'(bx1);
        i_seg_b_y1 <= coord_t'(by1);
        i_seg_b_x2 <= coord_t'(bx2);
        i_seg_b_y2 <= coord_t'(by2);
        start      <= 1'b1;
        do
            @(posedge i_clk);
        while (busy);
        transfers++;
    endtask

    // Drop start for a short burst of idle cycles.
    task automatic hold_off(input int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    // Drop start and wait, with a cap, until every transfer has its result.
    // The count is read at the falling edge, once the checker has settled.
    task automatic drain_results();
        int waited;
        start  <= 1'b0;
        waited = 0;
        @(negedge i_clk);
        while (awaiting != 0 && waited < DRAIN_WAIT) begin
            @(negedge i_clk);
            waited++;
        end
        @(posedge i_clk);
    endtask

    // Build one random pair into pair_coords. Most pairs are shaped so that they
    // cross, touch, run parallel or overlap; the rest are raw random bit patterns
    // and extreme values, which cover every bit of every coordinate.
    task automatic make_random_pair();
        int j, px, py, dx, dy, ux, uy, k, m, n, tmp;
        case ($urandom_range(0, 9))
            0, 1, 2: begin
                for (j = 0; j < 8; j++)
                    pair_coords[j] = $urandom;
            end
            3, 4, 5: begin
                // segment B straddles a point picked on segment A
                for (j = 0; j < 4; j++)
                    pair_coords[j] = int'($urandom_range(0, 32000)) - 16000;
                k  = $urandom_range(1, 255);
                px = pair_coords[0] + (pair_coords[2] - pair_coords[0]) * k / 256;
                py = pair_coords[1] + (pair_coords[3] - pair_coords[1]) * k / 256;
                dx = int'($urandom_range(0, 16000)) - 8000;
                dy = int'($urandom_range(0, 16000)) - 8000;
                m  = $urandom_range(1, 8);
                pair_coords[4] = px + dx;
                pair_coords[5] = py + dy;
                pair_coords[6] = px - dx * m / 4;
                pair_coords[7] = py - dy * m / 4;
            end
            6: begin
                // tiny grid: exact touches, shared points and collinear runs abound
                for (j = 0; j < 8; j++)
                    pair_coords[j] = int'($urandom_range(0, 6)) - 3;
            end
            7: begin
                // parallel copies and collinear overlaps of one direction
                ux = int'($urandom_range(0, 1000)) - 500;
                uy = int'($urandom_range(0, 1000)) - 500;
                pair_coords[0] = int'($urandom_range(0, 16000)) - 8000;
                pair_coords[1] = int'($urandom_range(0, 16000)) - 8000;
                pair_coords[2] = pair_coords[0] + 4 * ux;
                pair_coords[3] = pair_coords[1] + 4 * uy;
                if ($urandom_range(0, 1)) begin
                    dx = int'($urandom_range(0, 200)) - 100;
                    dy = int'($urandom_range(0, 200)) - 100;
                    pair_coords[4] = pair_coords[0] + dx;
                    pair_coords[5] = pair_coords[1] + dy;
                    pair_coords[6] = pair_coords[2] + dx;
                    pair_coords[7] = pair_coords[3] + dy;
                end else begin
                    m = int'($urandom_range(0, 12)) - 6;
                    n = int'($urandom_range(0, 12)) - 6;
                    pair_coords[4] = pair_coords[0] + m * ux;
                    pair_coords[5] = pair_coords[1] + m * uy;
                    pair_coords[6] = pair_coords[4] + n * ux;
                    pair_coords[7] = pair_coords[5] + n * uy;
                end
            end
            8: begin
                // one end of B lies exactly on A, often on one of A's ends
                ux = int'($urandom_range(0, 8000)) - 4000;
                uy = int'($urandom_range(0, 8000)) - 4000;
                pair_coords[0] = int'($urandom_range(0, 16000)) - 8000;
                pair_coords[1] = int'($urandom_range(0, 16000)) - 8000;
                pair_coords[2] = pair_coords[0] + 4 * ux;
                pair_coords[3] = pair_coords[1] + 4 * uy;
                k = $urandom_range(0, 4);
                pair_coords[4] = pair_coords[0] + k * ux;
                pair_coords[5] = pair_coords[1] + k * uy;
                pair_coords[6] = int'($urandom_range(0, 64000)) - 32000;
                pair_coords[7] = int'($urandom_range(0, 64000)) - 32000;
                if ($urandom_range(0, 1)) begin
                    tmp = pair_coords[4]; pair_coords[4] = pair_coords[6]; pair_coords[6] = tmp;
                    tmp = pair_coords[5]; pair_coords[5] = pair_coords[7]; pair_coords[7] = tmp;
                end
            end
            default: begin
                for (j = 0; j < 8; j++)
                    case ($urandom_range(0, 6))
                        0:       pair_coords[j] = -32768;
                        1:       pair_coords[j] = -32767;
                        2:       pair_coords[j] = -1;
                        3:       pair_coords[j] = 0;
                        4:       pair_coords[j] = 1;
                        5:       pair_coords[j] = 32766;
                        default: pair_coords[j] = 32767;
                    endcase
            end
        endcase
    endtask

    initial begin
        int k;
        // Hold every input at a known value through reset.
        i_rst_n    = 1'b0;
        start      = 1'b0;
        i_seg_a_x1 = '0;
        i_seg_a_y1 = '0;
        i_seg_a_x2 = '0;
        i_seg_a_y2 = '0;
        i_seg_b_x1 = '0;
        i_seg_b_y1 = '0;
        i_seg_b_x2 = '0;
        i_seg_b_y2 = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed pairs: plain crossings, crossings spanning the full range,
        // parallel, collinear and degenerate segments, touches at each end of
        // each parameter, near misses and truncation with negative quotients.
        issue_pair(0, 0, 160, 160, 0, 160, 160, 0);
        issue_pair(0, 0, 160, 160, 160, 0, 0, 160);
        issue_pair(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768);
        issue_pair(-32768, 0, 32767, 0, 0, -32768, 0, 32767);
        issue_pair(32767, -32768, -32768, 32767, -32768, -32768, 32767, 32767);
        hold_off(2);
        issue_pair(0, 0, 100, 50, 0, 10, 100, 60);
        issue_pair(0, 0, 100, 100, 50, 50, 150, 150);
        issue_pair(5, 5, 5, 5, 0, 0, 10, 10);
        issue_pair(7, -3, 7, -3, 7, -3, 7, -3);
        issue_pair(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767);
        issue_pair(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768);
        hold_off(1);
        issue_pair(0, 0, 100, 0, 0, -50, 0, 50);
        issue_pair(0, 0, 100, 0, 100, -50, 100, 50);
        issue_pair(-50, 0, 50, 0, 0, 0, 0, 80);
        issue_pair(-50, 0, 50, 0, 0, 80, 0, 0);
        issue_pair(0, 0, 100, 20, 100, 20, 30, 90);
        issue_pair(0, 0, 100, 0, 101, -50, 101, 50);
        hold_off(3);
        issue_pair(0, 0, 10, 10, 100, 0, 90, 10);
        issue_pair(-7, -3, 11, 5, -2, 9, 3, -13);
        issue_pair(-32768, -32767, 32767, 32767, -32768, -32768, 32767, 32766);
        issue_pair(-32768, 32767, 32767, -32768, 32767, 32767, -32768, -32767);

        // Random pairs. Idle in short bursts early on, pause once mid-run until
        // the pipeline has emptied, and run the tail back to back.
        for (k = 0; k < N_RANDOM; k++) begin
            make_random_pair();
            issue_pair(pair_coords[0], pair_coords[1], pair_coords[2], pair_coords[3],
                       pair_coords[4], pair_coords[5], pair_coords[6], pair_coords[7]);
            if (k == N_RANDOM / 2)
                drain_results();
            else if (k < N_RANDOM - CALM_TAIL && $urandom_range(0, 3) == 0)
                hold_off($urandom_range(1, 3));
        end

        // Let the last results through, then watch for stray strobes.
        drain_results();
        repeat (2 * LATENCY) @(posedge i_clk);

        if (awaiting != 0)
            $display("ERROR: %0d transfers never produced a result", awaiting);
        $display("Covered %0d segment pairs: directed cases, then crossings, touches,",
                 transfers);
        $display("parallel, collinear and extreme pairs; %0d results checked, %0d hits.",
                 results_seen, hits_seen);
        if (mismatches == 0 && awaiting == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
